@@ src/tpl_pkg.sv @@
// ============================================================================
// Time-window PID limiter package
// Shared widths, register indexes, reset values and the command type of the
// serial multiply-accumulate unit.
// ============================================================================
`default_nettype none

package tpl_pkg;

    // Algorithm constants (defaults of the top-level parameters).
    localparam int GAIN_DIVISOR  = 1000;
    localparam int FLOOR_DIVISOR = 20;

    // Field and register widths.
    localparam int W_GAIN     = 16;
    localparam int W_PCT      = 7;
    localparam int W_PERIOD   = 32;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 32;
    localparam int W_PREV     = W_PCT + 1;
    localparam int W_ERR_SUM  = 32;

    // Divider dividend covers period times a percent.
    localparam int W_DVD = W_PERIOD + W_PCT;

    // Accumulator: the weighted PID sum stays below 2^25 in magnitude, and
    // scaling by the period quotient plus the old allowance stays below 2^58.
    localparam int W_SUM  = 59;
    localparam int W_MPR  = W_PERIOD;
    localparam int W_MCNT = $clog2(W_MPR + 1);

    // Percent saturation point and register reset values.
    localparam logic [W_PCT-1:0]    PCT_FULL     = 7'd100;
    localparam logic [W_PERIOD-1:0] PERIOD_RESET = 32'd1000000;

    // Configuration register indexes.
    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INT_GAIN    = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_TARGET_PCT  = 3'd3,
        CFG_PERIOD_TIME = 3'd4
    } t_cfg_idx;

    // Command to the multiply-accumulate unit.
    typedef struct packed {
        logic              start;
        logic              load;
        logic [W_MCNT-1:0] cnt;
    } t_mac_cmd;

endpackage

`default_nettype wire

@@ src/time_window_pid_limiter_core.sv @@
// ============================================================================
// Time-window PID limiter
// Turns one measured utilization percent per scheduling window into the
// nanoseconds of the next window that the consumer may use, through a PID
// controller with a clamped integral and a quota floor on every step.
// ============================================================================
//
// Channel   Direction  Handshake                      Payload
// --------  ---------  -----------------------------  --------------------
// in        input      i_in_valid / o_in_stall        i_measured_pct[6:0]
// out       output     o_out_valid / i_out_stall      o_allowed_time[31:0]
// cfg       input      i_cfg_we (write only)          i_cfg_idx, i_cfg_data
//
// One transaction at a time. Each divide runs on the shared serial divider
// (one quotient bit per cycle over a 39-bit dividend), and each multiply
// steps through its multiplier of 7, 16 or 32 bits on the serial unit.
// After reset, the first transaction ends after the floor divide at a 100
// percent target, else after the target share; later ones run all PID steps.
// Reset is synchronous and active low; it clears the controller state and
// loads the register defaults. A finished result waits in the output register
// while the next transaction is already accepted and worked on.
// ============================================================================
`default_nettype none

module time_window_pid_limiter_core #(
    parameter int GAIN_DIVISOR  = tpl_pkg::GAIN_DIVISOR,
    parameter int FLOOR_DIVISOR = tpl_pkg::FLOOR_DIVISOR
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [tpl_pkg::W_PCT-1:0]          i_measured_pct,
    // Output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [tpl_pkg::W_PERIOD-1:0]            o_allowed_time,
    // Configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [tpl_pkg::W_CFG_IDX-1:0]      i_cfg_idx,
    input  wire logic [tpl_pkg::W_CFG_DATA-1:0]     i_cfg_data
);

    localparam int W_PCT    = tpl_pkg::W_PCT;
    localparam int W_GAIN   = tpl_pkg::W_GAIN;
    localparam int W_PERIOD = tpl_pkg::W_PERIOD;
    localparam int W_PREV   = tpl_pkg::W_PREV;
    localparam int W_ESUM   = tpl_pkg::W_ERR_SUM;
    localparam int W_SUM    = tpl_pkg::W_SUM;
    localparam int W_MPR    = tpl_pkg::W_MPR;
    localparam int W_MCNT   = tpl_pkg::W_MCNT;
    localparam int W_DVD    = tpl_pkg::W_DVD;

    // Divisor width covers every divisor the block uses.
    localparam int W_GD    = $clog2(GAIN_DIVISOR + 1);
    localparam int W_FD    = $clog2(FLOOR_DIVISOR + 1);
    localparam int W_HUND  = $clog2(int'(tpl_pkg::PCT_FULL) + 1);
    localparam int W_DVS_A = (W_GD > W_FD) ? W_GD : W_FD;
    localparam int W_DVS_B = (W_DVS_A > W_GAIN) ? W_DVS_A : W_GAIN;
    localparam int W_DVS   = (W_DVS_B > W_HUND) ? W_DVS_B : W_HUND;

    // Clamped integral fits the limit plus a sign bit.
    localparam int W_INT = W_DVS + 1;
    localparam int W_CLP = W_ESUM + 2;

    // Multiplier bit counts.
    localparam logic [W_MCNT-1:0] CNT_PCT  = W_MCNT'(W_PCT);
    localparam logic [W_MCNT-1:0] CNT_GAIN = W_MCNT'(W_GAIN);
    localparam logic [W_MCNT-1:0] CNT_Q    = W_MCNT'(W_MPR);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LEAST = 11'b000_0000_0010,
        S_PROD  = 11'b000_0000_0100,
        S_PDIV  = 11'b000_0000_1000,
        S_QDIV  = 11'b000_0001_0000,
        S_LDIV  = 11'b000_0010_0000,
        S_MP    = 11'b000_0100_0000,
        S_MI    = 11'b000_1000_0000,
        S_MD    = 11'b001_0000_0000,
        S_MQ    = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    // Configuration registers
    logic [W_GAIN-1:0]   r_prop_gain;
    logic [W_GAIN-1:0]   r_int_gain;
    logic [W_GAIN-1:0]   r_deriv_gain;
    logic [W_PCT-1:0]    r_target_pct;
    logic [W_PERIOD-1:0] r_period;

    // Controller state
    t_state                    r_state;
    t_state                    n_state;
    logic [W_PERIOD-1:0]       r_allowance;
    logic [W_ESUM-1:0]         r_error_sum;
    logic signed [W_PREV-1:0]  r_prev_error;

    // Per-transaction working registers
    logic [W_PCT-1:0]          r_meas;
    logic [W_PERIOD-1:0]       r_least;
    logic [W_PERIOD-1:0]       r_q;
    logic [W_PERIOD-1:0]       r_result;
    logic signed [W_INT-1:0]   r_integ;
    logic [W_PERIOD-1:0]       r_out;
    logic                      r_out_valid;

    // Combinational helpers
    logic                      in_acc;
    logic                      out_free;
    logic [W_PERIOD-1:0]       period_eff;
    logic [W_PCT-1:0]          target_sat;
    logic [W_PCT-1:0]          meas_sat;
    logic signed [W_PREV-1:0]  err;
    logic signed [W_PREV:0]    deriv;
    logic signed [W_CLP-1:0]   integ_sum;
    logic signed [W_CLP-1:0]   lim;
    logic signed [W_CLP-1:0]   integ_clamp;
    logic [W_PERIOD-1:0]       quo_low;
    logic [W_PERIOD-1:0]       share;
    logic signed [W_SUM-1:0]   res_lo;
    logic signed [W_SUM-1:0]   res_hi;
    logic [W_PERIOD-1:0]       res_clamp;

    // Divider and multiplier connections
    logic                      div_start;
    logic [W_DVD-1:0]          div_dividend;
    logic [W_DVS-1:0]          div_divisor;
    logic                      div_done;
    logic [W_DVD-1:0]          div_quo;
    tpl_pkg::t_mac_cmd         mac_cmd;
    logic [W_SUM-1:0]          mac_init;
    logic signed [W_SUM-1:0]   mac_mcd;
    logic [W_MPR-1:0]          mac_mpr;
    logic                      mac_done;
    logic signed [W_SUM-1:0]   mac_acc;

    // Handshakes
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Saturated percents, effective period, error and its change.
    assign period_eff = (r_period == '0) ? W_PERIOD'(1) : r_period;
    assign target_sat = (r_target_pct > tpl_pkg::PCT_FULL) ? tpl_pkg::PCT_FULL : r_target_pct;
    assign meas_sat   = (i_measured_pct > tpl_pkg::PCT_FULL) ? tpl_pkg::PCT_FULL
                                                              : i_measured_pct;
    assign err   = $signed({1'b0, target_sat}) - $signed({1'b0, r_meas});
    assign deriv = $signed({err[W_PREV-1], err})
                 - $signed({r_prev_error[W_PREV-1], r_prev_error});

    // Integral clamp against the limit that the divider just produced.
    assign integ_sum = W_CLP'($signed(r_error_sum)) + W_CLP'(err);
    assign lim       = $signed({{(W_CLP - W_DVS){1'b0}}, div_quo[W_DVS-1:0]});

    always_comb begin
        if (integ_sum < -lim) begin
            integ_clamp = -lim;
        end else if (integ_sum > lim) begin
            integ_clamp = lim;
        end else begin
            integ_clamp = integ_sum;
        end
    end

    // First-step share, raised to the minimum allowance.
    assign quo_low = div_quo[W_PERIOD-1:0];
    assign share   = (quo_low < r_least) ? r_least : quo_low;

    // New allowance clamped between the minimum and the period.
    assign res_lo = $signed({{(W_SUM - W_PERIOD){1'b0}}, r_least});
    assign res_hi = $signed({{(W_SUM - W_PERIOD){1'b0}}, period_eff});

    always_comb begin
        if (mac_acc < res_lo) begin
            res_clamp = r_least;
        end else if (mac_acc > res_hi) begin
            res_clamp = period_eff;
        end else begin
            res_clamp = mac_acc[W_PERIOD-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LEAST;
                end
            end
            S_LEAST: begin
                if (div_done) begin
                    if (r_allowance != '0) begin
                        n_state = S_QDIV;
                    end else if (target_sat == tpl_pkg::PCT_FULL) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_PROD;
                    end
                end
            end
            S_PROD: begin
                if (mac_done) begin
                    n_state = S_PDIV;
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_QDIV: begin
                if (div_done) begin
                    n_state = S_LDIV;
                end
            end
            S_LDIV: begin
                if (div_done) begin
                    n_state = S_MP;
                end
            end
            S_MP: begin
                if (mac_done) begin
                    n_state = S_MI;
                end
            end
            S_MI: begin
                if (mac_done) begin
                    n_state = S_MD;
                end
            end
            S_MD: begin
                if (mac_done) begin
                    n_state = S_MQ;
                end
            end
            S_MQ: begin
                if (mac_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Divider operands for the state being entered; the unit starts on entry.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = W_DVD'(period_eff);
        div_divisor  = W_DVS'(FLOOR_DIVISOR);
        case (n_state)
            S_LEAST: begin
                div_start = (r_state != S_LEAST);
            end
            S_PDIV: begin
                div_start    = (r_state != S_PDIV);
                div_dividend = mac_acc[W_DVD-1:0];
                div_divisor  = W_DVS'(tpl_pkg::PCT_FULL);
            end
            S_QDIV: begin
                div_start   = (r_state != S_QDIV);
                div_divisor = W_DVS'(GAIN_DIVISOR);
            end
            S_LDIV: begin
                div_start    = (r_state != S_LDIV);
                div_dividend = W_DVD'(GAIN_DIVISOR);
                div_divisor  = (r_int_gain == '0) ? W_DVS'(1) : W_DVS'(r_int_gain);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Multiplier operands for the state being entered.
    always_comb begin
        mac_cmd.start = 1'b0;
        mac_cmd.load  = 1'b1;
        mac_cmd.cnt   = CNT_GAIN;
        mac_init      = '0;
        mac_mcd       = W_SUM'(err);
        mac_mpr       = W_MPR'(r_prop_gain);
        case (n_state)
            S_PROD: begin
                mac_cmd.start = (r_state != S_PROD);
                mac_cmd.cnt   = CNT_PCT;
                mac_mcd       = $signed(W_SUM'(period_eff));
                mac_mpr       = W_MPR'(target_sat);
            end
            S_MP: begin
                mac_cmd.start = (r_state != S_MP);
            end
            S_MI: begin
                mac_cmd.start = (r_state != S_MI);
                mac_cmd.load  = 1'b0;
                mac_mcd       = W_SUM'(r_integ);
                mac_mpr       = W_MPR'(r_int_gain);
            end
            S_MD: begin
                mac_cmd.start = (r_state != S_MD);
                mac_cmd.load  = 1'b0;
                mac_mcd       = W_SUM'(deriv);
                mac_mpr       = W_MPR'(r_deriv_gain);
            end
            S_MQ: begin
                mac_cmd.start = (r_state != S_MQ);
                mac_cmd.cnt   = CNT_Q;
                mac_init      = W_SUM'(r_allowance);
                mac_mcd       = mac_acc;
                mac_mpr       = r_q;
            end
            default: begin
                mac_cmd.start = 1'b0;
            end
        endcase
    end

    // Control state, configuration registers and controller memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_allowance  <= '0;
            r_error_sum  <= '0;
            r_prev_error <= '0;
            r_prop_gain  <= '0;
            r_int_gain   <= '0;
            r_deriv_gain <= '0;
            r_target_pct <= tpl_pkg::PCT_FULL;
            r_period     <= tpl_pkg::PERIOD_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tpl_pkg::CFG_PROP_GAIN:   r_prop_gain  <= i_cfg_data[W_GAIN-1:0];
                    tpl_pkg::CFG_INT_GAIN:    r_int_gain   <= i_cfg_data[W_GAIN-1:0];
                    tpl_pkg::CFG_DERIV_GAIN:  r_deriv_gain <= i_cfg_data[W_GAIN-1:0];
                    tpl_pkg::CFG_TARGET_PCT:  r_target_pct <= i_cfg_data[W_PCT-1:0];
                    tpl_pkg::CFG_PERIOD_TIME: r_period     <= i_cfg_data[W_PERIOD-1:0];
                    default: begin
                    end
                endcase
            end

            // Result hand-off also commits the controller state.
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
                r_allowance <= r_result;
                if (r_allowance != '0) begin
                    r_error_sum  <= W_ESUM'(r_integ);
                    r_prev_error <= err;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of one transaction.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_meas <= meas_sat;
        end
        if ((r_state == S_LEAST) && div_done) begin
            r_least  <= (quo_low == '0) ? W_PERIOD'(1) : quo_low;
            r_result <= period_eff;
        end
        if ((r_state == S_PDIV) && div_done) begin
            r_result <= share;
        end
        if ((r_state == S_QDIV) && div_done) begin
            r_q <= quo_low;
        end
        if ((r_state == S_LDIV) && div_done) begin
            r_integ <= integ_clamp[W_INT-1:0];
        end
        if ((r_state == S_MQ) && mac_done) begin
            r_result <= res_clamp;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out <= r_result;
        end
    end

    // Shared serial divider
    tpl_div #(
        .W_DVD (W_DVD),
        .W_DVS (W_DVS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Serial multiply-accumulate unit
    tpl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .i_init  (mac_init),
        .i_mcd   (mac_mcd),
        .i_mpr   (mac_mpr),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_allowed_time = r_out;

    // A delivered allowance is never zero.
    a_out_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_allowed_time != '0))
        else $error("Allowed time of zero on the output.");

    // The offered result is the allowance that the controller now holds.
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_allowance == o_allowed_time))
        else $error("Output differs from the stored allowance.");

    // Once stepped, the allowance never returns to the not-yet-stepped value.
    a_allowance_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_allowance != '0) |=> (r_allowance != '0))
        else $error("Allowance fell back to zero.");

    // The integral never leaves the widest possible clamp range.
    a_err_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed(r_error_sum) <= $signed(W_ESUM'(GAIN_DIVISOR)))
        && ($signed(r_error_sum) >= -$signed(W_ESUM'(GAIN_DIVISOR))))
        else $error("Integral outside its clamp range.");

endmodule

`default_nettype wire

@@ src/tpl_div.sv @@
// ============================================================================
// Serial restoring divider
// Produces one quotient bit per cycle; the quotient shifts in where the
// dividend shifts out.
// ============================================================================
`default_nettype none

module tpl_div #(
    parameter int W_DVD = tpl_pkg::W_DVD,
    parameter int W_DVS = tpl_pkg::W_GAIN
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [W_DVD-1:0] i_dividend,
    input  wire logic [W_DVS-1:0] i_divisor,
    output logic                  o_done,
    output logic [W_DVD-1:0]      o_quotient
);

    localparam int W_CNT = $clog2(W_DVD);

    logic             r_busy;
    logic             r_done;
    logic [W_CNT-1:0] r_cnt;
    logic [W_DVS-1:0] r_rem;
    logic [W_DVS-1:0] r_dvs;
    logic [W_DVD-1:0] r_quo;

    logic [W_DVS:0]   trial;
    logic [W_DVS:0]   diff;
    logic             fits;

    // One trial subtraction per cycle.
    assign trial = {r_rem, r_quo[W_DVD-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = ~diff[W_DVS];

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= W_CNT'(W_DVD - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[W_DVS-1:0] : trial[W_DVS-1:0];
            r_quo <= {r_quo[W_DVD-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // The partial remainder always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("Divider remainder reached the divisor.");

endmodule

`default_nettype wire

@@ src/tpl_mac.sv @@
// ============================================================================
// Serial multiply-accumulate unit
// Adds a signed multiplicand times an unsigned multiplier into the loaded or
// kept accumulator, one multiplier bit per cycle, least significant bit first.
// ============================================================================
`default_nettype none

module tpl_mac (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tpl_pkg::t_mac_cmd               i_cmd,
    input  wire logic        [tpl_pkg::W_SUM-1:0] i_init,
    input  wire logic signed [tpl_pkg::W_SUM-1:0] i_mcd,
    input  wire logic        [tpl_pkg::W_MPR-1:0] i_mpr,
    output logic                                  o_done,
    output logic signed      [tpl_pkg::W_SUM-1:0] o_acc
);

    logic [tpl_pkg::W_MCNT-1:0]       r_left;
    logic                             r_done;
    logic signed [tpl_pkg::W_SUM-1:0] r_acc;
    logic signed [tpl_pkg::W_SUM-1:0] r_mcd;
    logic [tpl_pkg::W_MPR-1:0]        r_mpr;

    // Remaining multiplier bits and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_left <= i_cmd.cnt;
            r_done <= 1'b0;
        end else if (r_left != '0) begin
            r_left <= r_left - 1'b1;
            r_done <= (r_left == tpl_pkg::W_MCNT'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Shift-add datapath: multiplicand moves left, multiplier moves right.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            if (i_cmd.load) begin
                r_acc <= $signed(i_init);
            end
            r_mcd <= i_mcd;
            r_mpr <= i_mpr;
        end else if (r_left != '0) begin
            if (r_mpr[0]) begin
                r_acc <= r_acc + r_mcd;
            end
            r_mcd <= r_mcd <<< 1;
            r_mpr <= r_mpr >> 1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire
